>>> sv/permutation_rank_with_parity_unit_macros.svh
// Assertion macros shared by the permutation rank unit RTL.
`ifndef PERMUTATION_RANK_WITH_PARITY_UNIT_MACROS_SVH
`define PERMUTATION_RANK_WITH_PARITY_UNIT_MACROS_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define PRWP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("prwp: assertion failed");
// Check that a condition in one cycle implies another in the next cycle.
`define PRWP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prwp: assertion failed");
`else
`define PRWP_ASSERT(lbl, clk, rst_n, prop)
`define PRWP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/prwp_pkg.sv
// Shared types and constants of the permutation rank unit.
`default_nettype none
package prwp_pkg;

  localparam int MAX_ELEMENTS_DEF = 16;
  localparam int ELEM_W           = 4;
  localparam int SIZE_W           = 5;
  localparam int RANK_W           = 45;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 5;
  localparam int IN_TDATA_W       = 8;
  localparam int OUT_TDATA_W      = 48;
  localparam int OUTQ_DEPTH       = 4;
  localparam int OUTQ_PTR_W       = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W       = $clog2(OUTQ_DEPTH + 1);

  localparam logic [SIZE_W-1:0] PERM_SIZE_RST = SIZE_W'(16);
  localparam logic              EVEN_ONLY_RST = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERM_SIZE = 1'b0,
    CFG_EVEN_ONLY = 1'b1
  } cfg_reg_t;

  // Control from the pipeline to the map tables.
  typedef struct packed {
    logic rd;   // read both maps for the item being accepted
    logic wr;   // write back the swap of the item in stage 1
    logic clr;  // drop both maps back to identity
  } tbl_ctl_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              bad;
  } result_t;

endpackage
`default_nettype wire

>>> sv/prwp_tables.sv
// Position map and inverse map memories with swap write-back and forwarding.
`default_nettype none
`include "permutation_rank_with_parity_unit_macros.svh"
module prwp_tables
  import prwp_pkg::*;
#(
  parameter int TBL_DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire tbl_ctl_t                     ctl,
  input  wire logic [$clog2(TBL_DEPTH)-1:0] rd_elem,
  input  wire logic [$clog2(TBL_DEPTH)-1:0] rd_pos,
  output logic      [$clog2(TBL_DEPTH)-1:0] slot_j
);

  localparam int IDX_W = $clog2(TBL_DEPTH);

  logic [IDX_W-1:0] pos_mem [TBL_DEPTH];
  logic [IDX_W-1:0] inv_mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] pos_vld_r, inv_vld_r;

  logic [IDX_W-1:0] pos_rd_r, inv_rd_r;
  logic [IDX_W-1:0] pos_addr_r, inv_addr_r;
  logic             pos_hit_vld_r, inv_hit_vld_r;

  // Last write-back, for a read issued at the same edge.
  logic             fwd_vld_r;
  logic [IDX_W-1:0] fwd_inv_addr_r, fwd_inv_data_r;
  logic [IDX_W-1:0] fwd_pos_addr_r, fwd_pos_data_r;

  logic [IDX_W-1:0] inv_q, pos_q;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      inv_mem[pos_q] <= inv_q;
      pos_mem[inv_q] <= pos_q;
    end
    if (ctl.rd) begin
      inv_rd_r      <= inv_mem[rd_elem];
      pos_rd_r      <= pos_mem[rd_pos];
      inv_addr_r    <= rd_elem;
      pos_addr_r    <= rd_pos;
      inv_hit_vld_r <= inv_vld_r[rd_elem];
      pos_hit_vld_r <= pos_vld_r[rd_pos];
    end
    fwd_inv_addr_r <= pos_q;
    fwd_inv_data_r <= inv_q;
    fwd_pos_addr_r <= inv_q;
    fwd_pos_data_r <= pos_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_vld_r <= '0;
      inv_vld_r <= '0;
      fwd_vld_r <= 1'b0;
    end else begin
      fwd_vld_r <= ctl.wr && !ctl.clr;
      if (ctl.clr) begin
        pos_vld_r <= '0;
        inv_vld_r <= '0;
      end else if (ctl.wr) begin
        inv_vld_r[pos_q] <= 1'b1;
        pos_vld_r[inv_q] <= 1'b1;
      end
    end
  end

  // Unwritten entries read as identity; the previous write-back overrides memory.
  always_comb begin
    if (fwd_vld_r && (fwd_inv_addr_r == inv_addr_r)) begin
      inv_q = fwd_inv_data_r;
    end else if (inv_hit_vld_r) begin
      inv_q = inv_rd_r;
    end else begin
      inv_q = inv_addr_r;
    end
    if (fwd_vld_r && (fwd_pos_addr_r == pos_addr_r)) begin
      pos_q = fwd_pos_data_r;
    end else if (pos_hit_vld_r) begin
      pos_q = pos_rd_r;
    end else begin
      pos_q = pos_addr_r;
    end
  end

  assign slot_j = inv_q;

  `PRWP_ASSERT_NEXT(a_clr_drops_all, clk, rst_n, ctl.clr,
    (pos_vld_r == '0) && (inv_vld_r == '0))
  `PRWP_ASSERT_NEXT(a_wr_marks_valid, clk, rst_n, ctl.wr && !ctl.clr,
    pos_vld_r[fwd_pos_addr_r] && inv_vld_r[fwd_inv_addr_r])
  `PRWP_ASSERT_NEXT(a_fwd_only_after_wr, clk, rst_n, !ctl.wr || ctl.clr, !fwd_vld_r)

endmodule
`default_nettype wire

>>> sv/prwp_outq.sv
// Result queue between the rank pipeline and the output channel.
`default_nettype none
module prwp_outq
  import prwp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire result_t               push_data,
  input  wire logic                  pop_rdy,
  output logic                       head_vld,
  output result_t                    head_data,
  output logic [OUTQ_CNT_W-1:0]      fill
);

  result_t                q_mem [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [OUTQ_CNT_W-1:0]  cnt_r;
  logic                   pop;

  assign head_vld  = (cnt_r != '0);
  assign head_data = q_mem[rd_ptr_r];
  assign pop       = head_vld && pop_rdy;
  assign fill      = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + OUTQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OUTQ_PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + OUTQ_CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - OUTQ_CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/permutation_rank_with_parity_unit.sv
// Top level of the permutation rank unit: config, rank pipeline, tables, output queue.
//
// Usage: stream one permutation entry per transfer on the in_ channel
// (element in in_tdata[3:0]). After the perm_size-th entry of a permutation,
// one transfer leaves on the out_ channel carrying the mixed-radix rank in
// out_tdata[44:0] and a sticky bad-element flag in out_tuser.
// Configuration: cfg_idx 0 writes perm_size (clamped to 2..MAX_ELEMENTS),
// cfg_idx 1 writes even_only; write only while no permutation work is in flight.
// Throughput: one entry per cycle while in_tready is high, set by the read-modify-write
// of the two map memories (synchronous read, write-back in the next cycle,
// forwarding covers a read of the entry written at the same edge).
// Path: after the last entry's transfer, the result goes through the memory read,
// the rank product and the accumulate into the queue, then shows on out_tvalid.
// Reset: config returns to size 16, full mode; both maps read as identity at
// once through per-entry valid bits, so no clearing pass is needed.
// Stall: results wait in a four-entry queue; in_tready drops only when the
// queue plus results still in the pipeline could not take one more.
`default_nettype none
`include "permutation_rank_with_parity_unit_macros.svh"
module permutation_rank_with_parity_unit
  import prwp_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // in_tdata: [3:0] element, [7:4] zero
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: [44:0] rank_index, [47:45] zero
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // out_tuser: [0] bad_element
  output logic                        out_tuser,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // Table must also cover every element code.
  localparam int TBL_DEPTH = (MAX_ELEMENTS > (1 << ELEM_W)) ? MAX_ELEMENTS : (1 << ELEM_W);
  localparam int IDX_W     = $clog2(TBL_DEPTH);
  localparam int CNT_W     = $clog2(MAX_ELEMENTS + 1);
  localparam logic [SIZE_W-1:0] MAX_N = SIZE_W'(MAX_ELEMENTS);
  localparam logic [SIZE_W-1:0] MIN_N = SIZE_W'(2);

  // Configuration registers.
  logic [SIZE_W-1:0] perm_size_r;
  logic              even_only_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perm_size_r <= PERM_SIZE_RST;
      even_only_r <= EVEN_ONLY_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        CFG_PERM_SIZE: perm_size_r <= cfg_wdata;
        CFG_EVEN_ONLY: even_only_r <= cfg_wdata[0];
      endcase
    end
  end

  // Stage 0: accept, count, update radix product, issue table reads.
  logic [ELEM_W-1:0]        elem;
  logic                     in_acc;
  logic [SIZE_W-1:0]        n_eff, lim, cnt_ext, factor;
  logic                     do_swap, is_last, is_bad;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     err_r, err_nxt;
  logic [RANK_W-1:0]        radix_r, radix_nxt;
  logic [RANK_W+SIZE_W-1:0] rad_mul;

  assign elem   = in_tdata[ELEM_W-1:0];
  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    priority if (perm_size_r < MIN_N) begin
      n_eff = MIN_N;
    end else if (perm_size_r > MAX_N) begin
      n_eff = MAX_N;
    end else begin
      n_eff = perm_size_r;
    end
    lim     = even_only_r ? (n_eff - SIZE_W'(2)) : (n_eff - SIZE_W'(1));
    cnt_ext = SIZE_W'(cnt_r);
    do_swap = (cnt_ext < lim);
    is_last = ((cnt_ext + SIZE_W'(1)) >= n_eff);
    is_bad  = (SIZE_W'(elem) >= n_eff);
    factor  = n_eff - cnt_ext;
    rad_mul = (RANK_W+SIZE_W)'(radix_r) * (RANK_W+SIZE_W)'(factor);

    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    radix_nxt = radix_r;
    if (in_acc) begin
      if (is_last) begin
        cnt_nxt   = '0;
        err_nxt   = 1'b0;
        radix_nxt = RANK_W'(1);
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
        err_nxt = err_r || is_bad;
        if (do_swap) begin
          radix_nxt = rad_mul[RANK_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      err_r   <= 1'b0;
      radix_r <= RANK_W'(1);
    end else begin
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
      radix_r <= radix_nxt;
    end
  end

  // Stage 1 registers: item waiting on table read data.
  logic              s1_vld_r, s1_swap_r, s1_last_r, s1_err_r;
  logic [RANK_W-1:0] s1_radix_r;
  logic [IDX_W-1:0]  s1_i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc;
    end
    if (in_acc) begin
      s1_swap_r  <= do_swap;
      s1_last_r  <= is_last;
      s1_err_r   <= err_r || is_bad;
      s1_radix_r <= radix_r;
      s1_i_r     <= IDX_W'(cnt_r);
    end
  end

  tbl_ctl_t         tbl_ctl;
  logic [IDX_W-1:0] slot_j;

  always_comb begin
    tbl_ctl.rd  = in_acc;
    tbl_ctl.wr  = s1_vld_r && s1_swap_r;
    tbl_ctl.clr = in_acc && is_last;
  end

  prwp_tables #(
    .TBL_DEPTH (TBL_DEPTH)
  ) u_tables (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (tbl_ctl),
    .rd_elem (IDX_W'(elem)),
    .rd_pos  (IDX_W'(cnt_r)),
    .slot_j  (slot_j)
  );

  // Rank step: radix * (j - i), with the difference taken as signed; zero without a swap.
  logic signed [RANK_W:0]         rad_s;
  logic signed [IDX_W:0]          diff_s;
  logic signed [RANK_W+IDX_W+1:0] prod_full;
  logic [RANK_W-1:0]              prod;

  always_comb begin
    rad_s     = $signed({1'b0, s1_radix_r});
    diff_s    = $signed({1'b0, slot_j}) - $signed({1'b0, s1_i_r});
    prod_full = (RANK_W+IDX_W+2)'(rad_s) * (RANK_W+IDX_W+2)'(diff_s);
    prod      = s1_swap_r ? prod_full[RANK_W-1:0] : '0;
  end

  // Stage 2 registers: product ready to accumulate.
  logic              s2_vld_r, s2_last_r, s2_err_r;
  logic [RANK_W-1:0] s2_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    if (s1_vld_r) begin
      s2_last_r <= s1_last_r;
      s2_err_r  <= s1_err_r;
      s2_prod_r <= prod;
    end
  end

  // Accumulate; a last item pushes the finished rank and restarts the sum.
  logic [RANK_W-1:0] acc_r, acc_sum;
  logic              q_push;
  result_t           q_in, q_head;
  logic [OUTQ_CNT_W-1:0] q_fill;

  assign acc_sum   = acc_r + s2_prod_r;
  assign q_push    = s2_vld_r && s2_last_r;
  assign q_in.rank = acc_sum;
  assign q_in.bad  = s2_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (s2_vld_r) begin
      acc_r <= s2_last_r ? '0 : acc_sum;
    end
  end

  prwp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop_rdy   (out_tready),
    .head_vld  (out_tvalid),
    .head_data (q_head),
    .fill      (q_fill)
  );

  // Hold input while queued plus in-flight results leave no room for one more.
  logic [OUTQ_CNT_W:0] pending;

  assign pending   = (OUTQ_CNT_W + 1)'(q_fill) + (OUTQ_CNT_W + 1)'(s1_vld_r && s1_last_r)
                   + (OUTQ_CNT_W + 1)'(s2_vld_r && s2_last_r);
  assign in_tready = (pending < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH));

  assign out_tdata = {(OUT_TDATA_W - RANK_W)'(0), q_head.rank};
  assign out_tuser = q_head.bad;

  `PRWP_ASSERT(a_q_no_overflow, clk, rst_n,
    q_push |-> (q_fill < OUTQ_CNT_W'(OUTQ_DEPTH)))
  `PRWP_ASSERT_NEXT(a_last_restarts, clk, rst_n, in_acc && is_last,
    (cnt_r == '0) && (radix_r == RANK_W'(1)) && !err_r)
  `PRWP_ASSERT_NEXT(a_noswap_adds_zero, clk, rst_n, s1_vld_r && !s1_swap_r,
    s2_prod_r == '0)

endmodule
`default_nettype wire
